// ===== hdl/antialiased_line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the antialiased line rasterizer
// Shared check forms, sampled on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define ALR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("alr check failed");

// next-cycle implication
`define ALR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("alr check failed");

`endif

// ===== hdl/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// alr_pkg
// Types, constants and helpers shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alr_pkg;

   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 16;
   localparam int PIX_BITS    = COORD_BITS + 1;
   localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 1;
   localparam int SLOPE_BITS  = FRAC_BITS + 2;
   localparam int COV_BITS    = 8;
   localparam int COV_SHIFT   = FRAC_BITS - COV_BITS;
   localparam int DIV_BITS    = COORD_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [COV_BITS-1:0] COV_HALF = {1'b1, {(COV_BITS-1){1'b0}}};
   localparam logic [COV_BITS-1:0] COV_NONE = '0;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIVIDE,
      FR_PUSH
   } fr_state_type;

   typedef enum logic [1:0] {
      PH_FIRST    = 2'd0,
      PH_INTERIOR = 2'd1,
      PH_FINAL    = 2'd2
   } phase_type;

   // one queued command: a step, or the setup of a new line
   typedef struct packed {
      logic                  is_step;
      logic                  steep;
      logic [COORD_BITS-1:0] x0;
      logic [COORD_BITS-1:0] y0;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
      logic [SLOPE_BITS-1:0] slope;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // fraction (one integer bit) to 8-bit coverage, 1.0 saturates
   function automatic logic [COV_BITS-1:0] cov_sat(input logic [FRAC_BITS:0] v);
      logic [FRAC_BITS-COV_SHIFT:0] c;
      c = v[FRAC_BITS:COV_SHIFT];
      if (c[FRAC_BITS-COV_SHIFT]) begin
         return '1;
      end
      return c[COV_BITS-1:0];
   endfunction

endpackage

// ===== hdl/antialiased_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu antialiased line rasterizer: line setup with a serial slope divider,
// a command queue, and a pixel walker emitting two pixels per column.
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  req     | req_valid / req_stall          | opcode, two endpoints
//  rsp     | rsp_valid / rsp_stall          | pixel x, y, coverage, last
//
//  A step word yields two pixel words, one for each of the two rows; the
//  step leaves the queue with its second word, and a response stall holds the walk.
//  A start word holds the front through FR_DIVIDE, which forms a DIV_BITS (28) bit
//  quotient, and FR_PUSH; the back end keeps draining queued steps meanwhile.
//  Reset is synchronous and needs no clearing pass.
//  Either side may stall at any cycle; the queue decouples setup from drawing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module antialiased_line_rasterizer import alr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_BITS-1:0]   rsp_pixel_x,
   output logic [PIX_BITS-1:0]   rsp_pixel_y,
   output logic [COV_BITS-1:0]   rsp_coverage,
   output logic                  rsp_last
);

   q_stat_type q_stat;
   logic       q_push, q_pop;
   cmd_type    q_data, q_head;

   alr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   alr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   alr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .q_stat       (q_stat),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_coverage (rsp_coverage),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hdl/alr_front.sv =====
// ----------------------------------------------------------------------------
// alr_front
// Accepts request words, sets up new lines (endpoint ordering and a serial
// slope divider) and pushes commands into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "antialiased_line_rasterizer_defines.svh"

module alr_front import alr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  q_stat_type            q_stat,
   output logic                  q_push,
   output cmd_type               q_data
);

   fr_state_type state_ff, state_in;

   logic                    steep_ff, steep_in;
   logic [COORD_BITS-1:0]   x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_BITS-1:0]   dx_ff, dx_in;
   logic                    neg_ff, neg_in;
   logic [DIV_BITS-1:0]     dvd_ff, dvd_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [COORD_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                  accept;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  steep;
   logic [COORD_BITS-1:0] ax0, ay0, ax1, ay1;
   logic [COORD_BITS-1:0] ox0, oy0, ox1, oy1;
   logic [COORD_BITS:0]   trial;
   logic                  ge;
   logic [FRAC_BITS:0]    mag;
   logic [SLOPE_BITS-1:0] mag_ext;

   assign req_stall = (state_ff != FR_IDLE) || q_stat.full;
   assign accept    = req_valid && !req_stall;

   // steep test, then order endpoints so the walk column rises
   always_comb begin
      adx   = (req_x_end > req_x_start) ? req_x_end - req_x_start : req_x_start - req_x_end;
      ady   = (req_y_end > req_y_start) ? req_y_end - req_y_start : req_y_start - req_y_end;
      steep = ady > adx;
      ax0   = steep ? req_y_start : req_x_start;
      ay0   = steep ? req_x_start : req_y_start;
      ax1   = steep ? req_y_end   : req_x_end;
      ay1   = steep ? req_x_end   : req_y_end;
      if (ax0 > ax1) begin
         ox0 = ax1; oy0 = ay1; ox1 = ax0; oy1 = ay0;
      end else begin
         ox0 = ax0; oy0 = ay0; ox1 = ax1; oy1 = ay1;
      end
   end

   // one restoring division step per cycle
   assign trial = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign ge    = trial >= {1'b0, dx_ff};

   // |dy| <= dx, so the quotient fits one integer bit
   assign mag     = (dx_ff == '0) ? '0 : quo_ff[FRAC_BITS:0];
   assign mag_ext = {1'b0, mag};

   always_comb begin
      q_data.is_step = (state_ff == FR_IDLE);
      q_data.steep   = steep_ff;
      q_data.x0      = x0_ff;
      q_data.y0      = y0_ff;
      q_data.x1      = x1_ff;
      q_data.y1      = y1_ff;
      q_data.slope   = neg_ff ? (~mag_ext + SLOPE_BITS'(1)) : mag_ext;
   end

   always_comb begin
      state_in = state_ff;
      steep_in = steep_ff;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      dx_in    = dx_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_STEP) begin
                  q_push = 1'b1;
               end else begin
                  steep_in = steep;
                  x0_in    = ox0;
                  y0_in    = oy0;
                  x1_in    = ox1;
                  y1_in    = oy1;
                  dx_in    = ox1 - ox0;
                  neg_in   = oy1 < oy0;
                  dvd_in   = {((oy1 < oy0) ? oy0 - oy1 : oy1 - oy0), {FRAC_BITS{1'b0}}};
                  rem_in   = '0;
                  cnt_in   = DIV_CNT_BITS'(DIV_BITS - 1);
                  state_in = FR_DIVIDE;
               end
            end
         end
         FR_DIVIDE: begin
            rem_in = ge ? COORD_BITS'(trial - {1'b0, dx_ff}) : trial[COORD_BITS-1:0];
            dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
            quo_in = {quo_ff[DIV_BITS-2:0], ge};
            cnt_in = cnt_ff - DIV_CNT_BITS'(1);
            if (cnt_ff == '0) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff <= steep_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      dx_ff    <= dx_in;
      neg_ff   <= neg_in;
      dvd_ff   <= dvd_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   `ALR_ASSERT_NEXT(a_start_divides, accept && (req_opcode == OP_START), state_ff == FR_DIVIDE)
   `ALR_ASSERT_NEXT(a_divide_runs, (state_ff == FR_DIVIDE) && (cnt_ff != '0), state_ff == FR_DIVIDE)

endmodule

// ===== hdl/alr_queue.sv =====
// ----------------------------------------------------------------------------
// alr_queue
// Short command queue between the setup front and the pixel back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "antialiased_line_rasterizer_defines.svh"

module alr_queue import alr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_data,
   input  logic       pop,
   output cmd_type    head,
   output q_stat_type stat
);

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign stat.full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ALR_ASSERT_IMPL(a_no_overflow, push, !stat.full)
   `ALR_ASSERT_IMPL(a_no_underflow, pop, !stat.empty)

endmodule

// ===== hdl/alr_back.sv =====
// ----------------------------------------------------------------------------
// alr_back
// Walks the active line: two pixel words per step command, written into the
// response register one per cycle while it is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "antialiased_line_rasterizer_defines.svh"

module alr_back import alr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             head,
   input  q_stat_type          q_stat,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PIX_BITS-1:0] rsp_pixel_x,
   output logic [PIX_BITS-1:0] rsp_pixel_y,
   output logic [COV_BITS-1:0] rsp_coverage,
   output logic                rsp_last
);

   logic                  steep_ff, steep_in;
   logic                  active_ff, active_in;
   phase_type             phase_ff, phase_in;
   logic                  half_ff, half_in;
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] fin_col_ff, fin_col_in;
   logic [COORD_BITS-1:0] first_row_ff, first_row_in;
   logic [COORD_BITS-1:0] fin_row_ff, fin_row_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [SLOPE_BITS-1:0] slope_ff, slope_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COV_BITS-1:0]   rsp_cov_ff, rsp_cov_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  emit;
   logic [COORD_BITS-1:0] pix_col, pix_row_base;
   logic [PIX_BITS-1:0]   pix_row;
   logic [COV_BITS-1:0]   pix_cov;
   logic                  pix_last;
   logic [FRAC_BITS-1:0]  frac;
   logic [COORD_BITS:0]   col_next;
   logic                  col_done;
   logic [ACC_BITS-1:0]   slope_sx, head_slope_sx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign frac     = acc_ff[FRAC_BITS-1:0];
   assign col_next = {1'b0, cur_col_ff} + (COORD_BITS+1)'(1);
   assign col_done = col_next >= {1'b0, fin_col_ff};
   assign slope_sx = {{(ACC_BITS-SLOPE_BITS){slope_ff[SLOPE_BITS-1]}}, slope_ff};
   assign head_slope_sx = {{(ACC_BITS-SLOPE_BITS){head.slope[SLOPE_BITS-1]}}, head.slope};

   // pixel for the current column; half selects the lower row
   always_comb begin
      pix_last = 1'b0;
      case (phase_ff)
         PH_FIRST: begin
            pix_col      = cur_col_ff;
            pix_row_base = first_row_ff;
            pix_cov      = half_ff ? COV_NONE : COV_HALF;
         end
         PH_INTERIOR: begin
            pix_col      = cur_col_ff;
            pix_row_base = acc_ff[FRAC_BITS +: COORD_BITS];
            pix_cov      = half_ff ? cov_sat({1'b0, frac}) : cov_sat(FRAC_ONE - {1'b0, frac});
         end
         default: begin
            pix_col      = fin_col_ff;
            pix_row_base = fin_row_ff;
            pix_cov      = half_ff ? COV_NONE : COV_HALF;
            pix_last     = half_ff;
         end
      endcase
      pix_row = {1'b0, pix_row_base} + PIX_BITS'(half_ff);
   end

   always_comb begin
      steep_in     = steep_ff;
      active_in    = active_ff;
      phase_in     = phase_ff;
      half_in      = half_ff;
      cur_col_in   = cur_col_ff;
      fin_col_in   = fin_col_ff;
      first_row_in = first_row_ff;
      fin_row_in   = fin_row_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      if (!q_stat.empty) begin
         if (!head.is_step) begin
            q_pop        = 1'b1;
            steep_in     = head.steep;
            active_in    = 1'b1;
            phase_in     = PH_FIRST;
            half_in      = 1'b0;
            cur_col_in   = head.x0;
            fin_col_in   = head.x1;
            first_row_in = head.y0;
            fin_row_in   = head.y1;
            slope_in     = head.slope;
            acc_in       = {1'b0, head.y0, {FRAC_BITS{1'b0}}} + head_slope_sx;
         end else if (!active_ff) begin
            q_pop = 1'b1;
         end else if (out_free) begin
            emit = 1'b1;
            if (!half_ff) begin
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               q_pop   = 1'b1;
               case (phase_ff)
                  PH_FIRST: begin
                     if (col_done) begin
                        phase_in = PH_FINAL;
                     end else begin
                        cur_col_in = col_next[COORD_BITS-1:0];
                        phase_in   = PH_INTERIOR;
                     end
                  end
                  PH_INTERIOR: begin
                     acc_in = acc_ff + slope_sx;
                     if (col_done) begin
                        phase_in = PH_FINAL;
                     end else begin
                        cur_col_in = col_next[COORD_BITS-1:0];
                     end
                  end
                  default: begin
                     active_in = 1'b0;
                     phase_in  = PH_FIRST;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = steep_ff ? pix_row : {1'b0, pix_col};
         rsp_y_in     = steep_ff ? {1'b0, pix_col} : pix_row;
         rsp_cov_in   = pix_cov;
         rsp_last_in  = pix_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steep_ff     <= 1'b0;
         active_ff    <= 1'b0;
         phase_ff     <= PH_FIRST;
         half_ff      <= 1'b0;
         cur_col_ff   <= '0;
         fin_col_ff   <= '0;
         first_row_ff <= '0;
         fin_row_ff   <= '0;
         acc_ff       <= '0;
         slope_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         steep_ff     <= steep_in;
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         half_ff      <= half_in;
         cur_col_ff   <= cur_col_in;
         fin_col_ff   <= fin_col_in;
         first_row_ff <= first_row_in;
         fin_row_ff   <= fin_row_in;
         acc_ff       <= acc_in;
         slope_ff     <= slope_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel_x  = rsp_x_ff;
   assign rsp_pixel_y  = rsp_y_ff;
   assign rsp_coverage = rsp_cov_ff;
   assign rsp_last     = rsp_last_ff;

   `ALR_ASSERT_IMPL(a_half_in_line, half_ff, active_ff)
   `ALR_ASSERT_IMPL(a_last_empty, rsp_valid_ff && rsp_last_ff, rsp_cov_ff == COV_NONE)

endmodule
